@@ rtl/tepe_pkg.sv @@
// ----------------------------------------------------------------------------
// tepe_pkg
// Shared types, constants and header helpers for the trace event packet encoder.
// ----------------------------------------------------------------------------
package tepe_pkg;

   localparam int CHANNEL_BYTES_DEF = 1024;
   localparam int SEG_COUNT         = 9;
   localparam int SEG_IDX_W         = 4;

   // segment slots in transmit order
   localparam logic [SEG_IDX_W-1:0] SEG_OVF_HDR   = 4'd0;
   localparam logic [SEG_IDX_W-1:0] SEG_OVF_CNT   = 4'd1;
   localparam logic [SEG_IDX_W-1:0] SEG_OVF_DELTA = 4'd2;
   localparam logic [SEG_IDX_W-1:0] SEG_EV_HDR    = 4'd3;
   localparam logic [SEG_IDX_W-1:0] SEG_EV_DELTA  = 4'd8;

   // register indexes
   localparam logic [1:0] REG_KNOWN_LAST_ID = 2'd0;
   localparam logic [1:0] REG_OVERFLOW_ID   = 2'd1;
   localparam logic [1:0] REG_TRACE_ENABLE  = 2'd2;

   localparam logic [7:0] CONT_BIT = 8'h80;

   // one piece of a packet: up to five bytes and a byte count
   typedef struct packed {
      logic [4:0][7:0] bytes;
      logic [2:0]      len;
   } seg_type;

   // header: id alone when it is known, else one- or two-byte id followed by payload length
   function automatic seg_type hdr_encode(input logic [13:0] id,
                                          input logic [7:0]  known,
                                          input logic [4:0]  plen);
      seg_type s;
      s = '0;
      if (id <= {6'd0, known}) begin
         s.bytes[0] = id[7:0];
         s.len      = 3'd1;
      end else if (id[13:7] != 7'd0) begin
         s.bytes[0] = {1'b1, id[6:0]};
         s.bytes[1] = {1'b0, id[13:7]};
         s.bytes[2] = {3'd0, plen};
         s.len      = 3'd3;
      end else begin
         s.bytes[0] = id[7:0];
         s.bytes[1] = {3'd0, plen};
         s.len      = 3'd2;
      end
      return s;
   endfunction

endpackage

@@ rtl/tepe_lane.sv @@
// ----------------------------------------------------------------------------
// tepe_lane
// One varint lane: splits a 32-bit word into 7-bit little-endian groups.
// ----------------------------------------------------------------------------
module tepe_lane (
   input  logic [31:0]           value,
   output tepe_pkg::seg_type     seg
);

   logic [2:0] len;

   // byte count from the highest set group
   always_comb begin
      if (value[31:28] != 4'd0)      len = 3'd5;
      else if (value[27:21] != 7'd0) len = 3'd4;
      else if (value[20:14] != 7'd0) len = 3'd3;
      else if (value[13:7] != 7'd0)  len = 3'd2;
      else                           len = 3'd1;
   end

   // groups with the continuation bit on all but the final one
   always_comb begin
      seg.len = len;
      for (int i = 0; i < 4; i++) begin
         seg.bytes[i] = {(3'(i) < len - 3'd1), value[7*i +: 7]};
      end
      seg.bytes[4] = {4'd0, value[31:28]};
   end

endmodule

@@ rtl/tepe_serializer.sv @@
// ----------------------------------------------------------------------------
// tepe_serializer
// Walks the segments of one job and sends one byte beat per cycle while rsp_tready does not stall.
// ----------------------------------------------------------------------------
module tepe_serializer (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         job_valid,
   input  tepe_pkg::seg_type [tepe_pkg::SEG_COUNT-1:0]  job_segs,
   input  logic                                         job_dropped,
   output logic                                         job_pop,
   output logic                                         rsp_tvalid,
   input  logic                                         rsp_tready,
   output logic [15:0]                                  rsp_tdata,  // out_byte, end_of_packet, event_dropped
   output logic [1:0]                                   rsp_tuser,  // byte_valid, is_overflow
   output logic                                         rsp_tlast
);

   localparam int SW = tepe_pkg::SEG_IDX_W;

   typedef struct packed {
      logic          found;
      logic [SW-1:0] idx;
   } pick_type;

   // lowest nonempty segment above a start point
   function automatic pick_type first_seg(input tepe_pkg::seg_type [tepe_pkg::SEG_COUNT-1:0] s,
                                          input logic [SW:0] from);
      pick_type p;
      p = '0;
      for (int i = tepe_pkg::SEG_COUNT - 1; i >= 0; i--) begin
         if (s[i].len != 3'd0 && $signed({1'b0, SW'(i)}) > $signed(from)) begin
            p.found = 1'b1;
            p.idx   = SW'(i);
         end
      end
      return p;
   endfunction

   tepe_pkg::seg_type [tepe_pkg::SEG_COUNT-1:0] segs_ff, segs_in;
   logic          busy_ff, busy_in;
   logic          stat_ff, stat_in;
   logic          drop_ff, drop_in;
   logic [SW-1:0] seg_ff, seg_in;
   logic [2:0]    idx_ff, idx_in;
   logic          rsp_tvalid_ff, rsp_tvalid_in;
   logic [15:0]   rsp_tdata_ff, rsp_tdata_in;
   logic [1:0]    rsp_tuser_ff, rsp_tuser_in;
   logic          rsp_tlast_ff, rsp_tlast_in;

   logic     out_ok, emit, byte_end, fin;
   pick_type nxt, first;
   tepe_pkg::seg_type cur;

   // beat decode
   always_comb begin
      out_ok   = !rsp_tvalid_ff || rsp_tready;
      emit     = busy_ff && out_ok;
      cur      = segs_ff[seg_ff];
      byte_end = (idx_ff == cur.len - 3'd1);
      nxt      = first_seg(segs_ff, {1'b0, seg_ff});
      first    = first_seg(job_segs, '1);
      fin      = stat_ff || (byte_end && !nxt.found);
      job_pop  = job_valid && (!busy_ff || (emit && fin));
   end

   // walk control
   always_comb begin
      segs_in = segs_ff;
      busy_in = busy_ff;
      stat_in = stat_ff;
      drop_in = drop_ff;
      seg_in  = seg_ff;
      idx_in  = idx_ff;
      if (job_pop) begin
         segs_in = job_segs;
         busy_in = 1'b1;
         stat_in = !first.found;
         drop_in = job_dropped;
         seg_in  = first.idx;
         idx_in  = 3'd0;
      end else if (emit && fin) begin
         busy_in = 1'b0;
      end else if (emit) begin
         if (byte_end) begin
            seg_in = nxt.idx;
            idx_in = 3'd0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
   end

   // output beat register
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      if (out_ok) begin
         rsp_tvalid_in = emit;
         rsp_tdata_in  = {6'd0, drop_ff,
                          !stat_ff && byte_end && (seg_ff == tepe_pkg::SEG_OVF_DELTA ||
                                                   seg_ff == tepe_pkg::SEG_EV_DELTA),
                          stat_ff ? 8'd0 : cur.bytes[idx_ff]};
         rsp_tuser_in  = {!stat_ff && seg_ff <= tepe_pkg::SEG_OVF_DELTA, !stat_ff};
         rsp_tlast_in  = fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      segs_ff      <= segs_in;
      stat_ff      <= stat_in;
      drop_ff      <= drop_in;
      seg_ff       <= seg_in;
      idx_ff       <= idx_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

@@ rtl/trace_event_packet_encoder_unit.sv @@
// ----------------------------------------------------------------------------
// trace_event_packet_encoder_unit
// Encodes trace events into varint byte packets with overflow reporting.
// ----------------------------------------------------------------------------
// Usage: one event beat on req_* (id, argument count and words, timestamp,
// free channel bytes). At the accepting edge six varint lanes encode the
// arguments, drop count and timestamp delta; the fit decision and the state
// update (last sent time, drop count) are made in that same cycle.
// The job then waits in one holding register until the serializer is free;
// the serializer sends one rsp_* beat per cycle: the optional overflow packet,
// then the event packet, or one status-only beat when nothing is sent.
// The first beat passes the holding register, the serializer walk registers
// and its output beat register. An event has 1 to 37 result beats on the
// byte-wide output; a new event is taken while the previous one drains.
// A stalled rsp_tready holds the output beat and the walk; req_tready falls
// once the holding register is full. Reset clears the state and registers
// to their defaults (tracing disabled) and empties the pipeline.
// csr_* writes take effect at once; the user must make them only while idle, as the block does not enforce it.
// ----------------------------------------------------------------------------
module trace_event_packet_encoder_unit #(
   parameter int CHANNEL_BYTES = tepe_pkg::CHANNEL_BYTES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [223:0] req_tdata,  // event_id, arg_count, arg_zero, arg_one, arg_two,
                                    // arg_three, now_time, space_free
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [15:0]  rsp_tdata,  // out_byte, end_of_packet, event_dropped
   output logic [1:0]   rsp_tuser,  // byte_valid, is_overflow
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [13:0]  csr_wdata
);

   localparam int NS = tepe_pkg::SEG_COUNT;

   // input fields
   logic [13:0] event_id;
   logic [2:0]  arg_count;
   logic [3:0][31:0] args;
   logic [31:0] now_lo;
   logic [10:0] space_free;

   assign event_id   = req_tdata[13:0];
   assign arg_count  = req_tdata[16:14];
   assign args[0]    = req_tdata[48:17];
   assign args[1]    = req_tdata[80:49];
   assign args[2]    = req_tdata[112:81];
   assign args[3]    = req_tdata[144:113];
   assign now_lo     = req_tdata[176:145];
   assign space_free = req_tdata[219:209];

   // registers and state
   logic [7:0]  known_ff;
   logic [13:0] ovf_id_ff;
   logic        enable_ff;
   logic [31:0] last_time_ff, last_time_in;
   logic [31:0] drop_cnt_ff, drop_cnt_in;
   logic        job_valid_ff, job_valid_in;
   tepe_pkg::seg_type [NS-1:0] job_segs_ff, job_segs_in;
   logic        job_drop_ff, job_drop_in;
   logic        job_pop, accept;

   // lanes
   tepe_pkg::seg_type [3:0] arg_seg;
   tepe_pkg::seg_type cnt_seg, delta_seg;
   logic [31:0] delta;

   assign delta = now_lo - last_time_ff;

   for (genvar g = 0; g < 4; g++) begin : g_arg
      tepe_lane u_arg (.value(args[g]), .seg(arg_seg[g]));
   end
   tepe_lane u_cnt   (.value(drop_cnt_ff), .seg(cnt_seg));
   tepe_lane u_delta (.value(delta),       .seg(delta_seg));

   // merge: sizes, fit decision and segment list
   logic [2:0]  n_args;
   logic [4:0]  plen;
   logic [10:0] room, room2;
   logic [5:0]  ovf_len, ev_len;
   logic        try_ovf, ovf_sent, ev_sent;
   tepe_pkg::seg_type ovf_hdr, ev_hdr, ev_delta;
   logic [31:0] drop_inc;

   always_comb begin
      n_args = (arg_count > 3'd4) ? 3'd4 : arg_count;
      plen   = '0;
      for (int i = 0; i < 4; i++) begin
         if (3'(i) < n_args) plen = plen + {2'd0, arg_seg[i].len};
      end
      room = ({6'd0, space_free} > 17'(CHANNEL_BYTES)) ? 11'(CHANNEL_BYTES) : space_free;
      ovf_hdr  = tepe_pkg::hdr_encode(ovf_id_ff, known_ff, {2'd0, cnt_seg.len});
      ovf_len  = {3'd0, ovf_hdr.len} + {3'd0, cnt_seg.len} + {3'd0, delta_seg.len};
      try_ovf  = enable_ff && (drop_cnt_ff != 32'd0);
      ovf_sent = try_ovf && ({5'd0, ovf_len} <= room);
      room2    = ovf_sent ? room - {5'd0, ovf_len} : room;
      ev_delta = ovf_sent ? tepe_pkg::seg_type'{bytes: '0, len: 3'd1} : delta_seg;
      ev_hdr   = tepe_pkg::hdr_encode(event_id, known_ff, plen);
      ev_len   = {3'd0, ev_hdr.len} + {1'b0, plen} + {3'd0, ev_delta.len};
      ev_sent  = enable_ff && !(try_ovf && !ovf_sent) && ({5'd0, ev_len} <= room2);
      drop_inc = (drop_cnt_ff == '1) ? drop_cnt_ff : drop_cnt_ff + 32'd1;

      job_segs_in = job_segs_ff;
      job_drop_in = job_drop_ff;
      if (accept) begin
         job_segs_in[tepe_pkg::SEG_OVF_HDR]   = ovf_hdr;
         job_segs_in[tepe_pkg::SEG_OVF_CNT]   = cnt_seg;
         job_segs_in[tepe_pkg::SEG_OVF_DELTA] = delta_seg;
         for (int i = 0; i < 3; i++) begin
            if (!ovf_sent) job_segs_in[i].len = 3'd0;
         end
         job_segs_in[tepe_pkg::SEG_EV_HDR]   = ev_hdr;
         job_segs_in[tepe_pkg::SEG_EV_DELTA] = ev_delta;
         for (int i = 0; i < 4; i++) begin
            job_segs_in[4 + i] = arg_seg[i];
            if (3'(i) >= n_args) job_segs_in[4 + i].len = 3'd0;
         end
         for (int i = 3; i < NS; i++) begin
            if (!ev_sent) job_segs_in[i].len = 3'd0;
         end
         job_drop_in = !ev_sent;
      end
   end

   // state update at acceptance
   always_comb begin
      accept       = req_tvalid && req_tready;
      last_time_in = last_time_ff;
      drop_cnt_in  = drop_cnt_ff;
      if (accept && enable_ff) begin
         if (ev_sent) begin
            drop_cnt_in  = '0;
            last_time_in = now_lo;
         end else if (ovf_sent) begin
            drop_cnt_in  = 32'd1;
            last_time_in = now_lo;
         end else begin
            drop_cnt_in  = drop_inc;
         end
      end
      job_valid_in = accept || (job_valid_ff && !job_pop);
   end

   assign req_tready = !job_valid_ff || job_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         known_ff     <= 8'd23;
         ovf_id_ff    <= 14'd1;
         enable_ff    <= 1'b0;
         last_time_ff <= '0;
         drop_cnt_ff  <= '0;
         job_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               tepe_pkg::REG_KNOWN_LAST_ID: known_ff  <= csr_wdata[7:0];
               tepe_pkg::REG_OVERFLOW_ID:   ovf_id_ff <= csr_wdata;
               tepe_pkg::REG_TRACE_ENABLE:  enable_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         last_time_ff <= last_time_in;
         drop_cnt_ff  <= drop_cnt_in;
         job_valid_ff <= job_valid_in;
      end
      job_segs_ff <= job_segs_in;
      job_drop_ff <= job_drop_in;
   end

   tepe_serializer u_ser (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (job_valid_ff),
      .job_segs    (job_segs_ff),
      .job_dropped (job_drop_ff),
      .job_pop     (job_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   // checks
   a_disabled_keeps_state: assert property (@(posedge clock) disable iff (reset)
      accept && !enable_ff && !csr_we |=> $stable(drop_cnt_ff) && $stable(last_time_ff))
      else $error("state changed while tracing disabled");

   a_sent_clears_drops: assert property (@(posedge clock) disable iff (reset)
      accept && ev_sent |=> drop_cnt_ff == 32'd0)
      else $error("drop count not cleared after sent event");

   a_job_kept: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff && !job_pop |=> job_valid_ff)
      else $error("pending job lost");

endmodule
